### hdl/vhd_pkg.sv
`timescale 1ns / 1ps
package vhd_pkg;
  localparam int REG_NEXT_STATE = 0;
  localparam int REG_EXPECTED = 1;
  localparam int TABLE_W = 16;
  localparam int METRIC_MAX = 255;

  typedef struct packed {
    logic rx0;
    logic rx1;
    logic eof;
  } stage_item_t;

  typedef struct packed {
    logic decoded_bit;
    logic [5:0] stage_index;
    logic last_of_run;
    logic [6:0] frame_length;
    logic overflow;
  } result_t;

  // Returns the 2-bit field of a packed table for one (state,input) entry.
  function automatic logic [1:0] table_field(input logic [TABLE_W-1:0] tbl,
                                             input logic [3:0] e);
    logic [1:0] r;
    r = 2'd0;
    if (e < 4'd8) begin
      r = tbl[{e[2:0], 1'b0} +: 2];
    end
    return r;
  endfunction
endpackage

### hdl/vhd_if.sv
`timescale 1ns / 1ps
interface vhd_in_if;
  logic valid;
  logic ready;
  logic first_bit;
  logic second_bit;
  logic end_of_frame;
  modport source (output valid, first_bit, second_bit, end_of_frame, input ready);
  modport sink (input valid, first_bit, second_bit, end_of_frame, output ready);
endinterface

interface vhd_out_if;
  logic valid;
  logic ready;
  logic decoded_bit;
  logic [5:0] stage_index;
  logic last_of_run;
  logic [6:0] frame_length;
  logic overflow;
  modport source (output valid, decoded_bit, stage_index, last_of_run, frame_length,
                  overflow, input ready);
  modport sink (input valid, decoded_bit, stage_index, last_of_run, frame_length,
                overflow, output ready);
endinterface

interface vhd_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/vhd_ram.sv
`timescale 1ns / 1ps
module vhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/vhd_front.sv
`timescale 1ns / 1ps
module vhd_front (
  input  logic                 clk,
  input  logic                 rst,
  vhd_in_if.sink               in_ch,
  output logic                 q_valid,
  input  logic                 q_ready,
  output vhd_pkg::stage_item_t q_item
);
  import vhd_pkg::*;

  // Two-entry queue decouples acceptance from ACS/traceback.
  stage_item_t buf_q [2];
  logic [1:0]  count;
  logic        rd_ptr;
  logic        wr_ptr;
  logic        push;
  logic        pop;

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= '{rx0: in_ch.first_bit, rx1: in_ch.second_bit,
                         eof: in_ch.end_of_frame};
    end
    if (rst) begin
      count <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### hdl/vhd_back.sv
`timescale 1ns / 1ps
module vhd_back #(
  parameter int N_STATES = 4,
  parameter int MAX_STAGES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  vhd_cfg_if.sink              cfg,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  vhd_pkg::stage_item_t q_item,
  vhd_out_if.source            out_ch
);
  import vhd_pkg::*;

  localparam int SW = (N_STATES > 1) ? $clog2(N_STATES) : 1;
  localparam int TW = $clog2(MAX_STAGES);
  localparam int AW = $clog2(MAX_STAGES * N_STATES);
  localparam int CW = $clog2(MAX_STAGES + 1);
  localparam int DEPTH = 1 << AW;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ACS   = 4'b0010,
    S_READ  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state;
  logic [TABLE_W-1:0] ns_tbl, eo_tbl;
  logic [7:0] metric [N_STATES];
  logic [N_STATES-1:0] reach;
  logic [7:0] new_metric [N_STATES];
  logic [N_STATES-1:0] new_reach;
  logic [7:0] fin_metric [N_STATES];
  logic [N_STATES-1:0] fin_reach;
  logic [SW-1:0] prev_s;
  logic [CW-1:0] stage_count;
  logic ovf;
  logic [1:0] rx;
  logic eof;
  logic [TW-1:0] t;
  logic [SW-1:0] st;
  logic [CW-1:0] run_len;
  logic run_ovf;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [SW:0] wdata, rdata;

  // Both branches of prev_s are evaluated here; ACS commits them one branch at a time.
  logic [3:0] e0, e1;
  logic [1:0] n0, n1, d0, d1;
  logic [8:0] m0, m1;
  logic [7:0] s0, s1;
  logic v0, v1, take0, take1_over0, same;
  logic [SW-1:0] t0, t1;

  always_comb begin
    e0 = 4'({prev_s, 1'b0});
    e1 = 4'({prev_s, 1'b1});
    n0 = table_field(ns_tbl, e0);
    n1 = table_field(ns_tbl, e1);
    d0 = rx ^ table_field(eo_tbl, e0);
    d1 = rx ^ table_field(eo_tbl, e1);
    m0 = {1'b0, metric[prev_s]} + {8'd0, d0[0]} + {8'd0, d0[1]};
    m1 = {1'b0, metric[prev_s]} + {8'd0, d1[0]} + {8'd0, d1[1]};
    s0 = m0[8] ? 8'(METRIC_MAX) : m0[7:0];
    s1 = m1[8] ? 8'(METRIC_MAX) : m1[7:0];
    v0 = reach[prev_s] && ({2'b00, n0} < 4'(N_STATES));
    v1 = reach[prev_s] && ({2'b00, n1} < 4'(N_STATES));
    t0 = SW'(n0);
    t1 = SW'(n1);
    take0 = v0 && (!new_reach[t0] || s0 < new_metric[t0]);
    same = (n0 == n1);
    if (same && take0) begin
      take1_over0 = v1 && (s1 < s0);
    end else begin
      take1_over0 = v1 && (!new_reach[t1] || s1 < new_metric[t1]);
    end
  end

  // Metrics and reach flags at the end of a stage, including the last branch.
  always_comb begin
    fin_reach = new_reach;
    for (int i = 0; i < N_STATES; i++) fin_metric[i] = new_metric[i];
    if (take1_over0) begin
      fin_reach[t1] = 1'b1;
      fin_metric[t1] = s1;
    end
  end

  logic [SW-1:0] clr_s;
  logic clr_phase;

  // Two writes per prev state can happen; the clear phase of ACS first clears this stage's
  // survivor row sequentially, then branches are written one per cycle.
  logic acs_branch;

  always_comb begin
    we = 1'b0;
    waddr = {AW{1'b0}};
    wdata = '0;
    if (state == S_ACS) begin
      if (clr_phase) begin
        we = 1'b1;
        waddr = AW'(stage_count * N_STATES + {{(CW-SW){1'b0}}, clr_s});
      end else if (!acs_branch ? take0 : take1_over0) begin
        we = 1'b1;
        waddr = AW'(stage_count * N_STATES + {{(CW-SW){1'b0}},
                    (!acs_branch ? t0 : t1)});
        wdata = {prev_s, acs_branch};
      end
    end
    raddr = AW'({{(AW-TW){1'b0}}, t} * N_STATES + st);
  end

  vhd_ram #(.WIDTH(SW + 1), .DEPTH(DEPTH)) u_surv (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign q_ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ns_tbl <= '0;
      eo_tbl <= '0;
      reach <= N_STATES'(1);
      stage_count <= '0;
      ovf <= 1'b0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < N_STATES; i++) metric[i] <= 8'd0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == 1'(REG_NEXT_STATE)) ns_tbl <= cfg.data;
        else eo_tbl <= cfg.data;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            rx <= {q_item.rx1, q_item.rx0};
            eof <= q_item.eof;
            if (stage_count < CW'(MAX_STAGES)) begin
              state <= S_ACS;
              clr_phase <= 1'b1;
              clr_s <= '0;
              prev_s <= '0;
              acs_branch <= 1'b0;
              new_reach <= '0;
              for (int i = 0; i < N_STATES; i++) new_metric[i] <= 8'd0;
            end else begin
              ovf <= 1'b1;
              if (q_item.eof) begin
                state <= (stage_count == '0) ? S_IDLE : S_READ;
                run_len <= stage_count;
                run_ovf <= 1'b1;
                t <= TW'(stage_count - 1'b1);
                st <= '0;
              end
            end
          end
        end
        S_ACS: begin
          if (clr_phase) begin
            if (clr_s == SW'(N_STATES - 1)) clr_phase <= 1'b0;
            else clr_s <= clr_s + 1'b1;
          end else begin
            if (!acs_branch) begin
              if (take0) begin
                new_reach[t0] <= 1'b1;
                new_metric[t0] <= s0;
              end
              acs_branch <= 1'b1;
            end else begin
              if (take1_over0) begin
                new_reach[t1] <= 1'b1;
                new_metric[t1] <= s1;
              end
              acs_branch <= 1'b0;
              if (prev_s == SW'(N_STATES - 1)) begin
                state <= eof ? S_READ : S_IDLE;
                stage_count <= stage_count + 1'b1;
                reach <= fin_reach;
                for (int i = 0; i < N_STATES; i++) metric[i] <= fin_metric[i];
                run_len <= stage_count + 1'b1;
                run_ovf <= ovf;
                t <= TW'(stage_count);
                st <= '0;
              end else begin
                prev_s <= prev_s + 1'b1;
              end
            end
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_ch.valid) begin
            out_ch.valid <= 1'b1;
            out_ch.decoded_bit <= rdata[0];
            out_ch.stage_index <= 6'(t);
            out_ch.last_of_run <= (t == '0);
            out_ch.frame_length <= 7'(run_len);
            out_ch.overflow <= run_ovf;
          end else if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            if (out_ch.last_of_run) begin
              state <= S_IDLE;
              stage_count <= '0;
              ovf <= 1'b0;
              reach <= N_STATES'(1);
              for (int i = 0; i < N_STATES; i++) metric[i] <= 8'd0;
            end else begin
              t <= t - 1'b1;
              st <= (rdata[SW:1] < SW'(N_STATES - 1) ||
                     rdata[SW:1] == SW'(N_STATES - 1)) ? rdata[SW:1] : '0;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### hdl/viterbi_hard_decision_decoder.sv
`timescale 1ns / 1ps
// Each stage runs an ACS pass: a clear phase over its survivor row, then both branches of every state in turn.
// A frame end adds a traceback through S_READ and S_EMIT per decoded bit, stalling while the output is not ready.
// One stage is decoded per ACS pass; input stalls during ACS and traceback once the two-entry queue is full.
// Reset (rst, synchronous, active high) clears tables, metrics, counters and queue.
// Survivor memory needs no clearing pass; each stage row is cleared on its ACS pass.
module viterbi_hard_decision_decoder #(
  parameter int N_STATES = 4,
  parameter int MAX_STAGES = 64
) (
  input logic       clk,
  input logic       rst,
  vhd_cfg_if.sink   cfg,
  vhd_in_if.sink    in_ch,
  vhd_out_if.source out_ch
);
  import vhd_pkg::*;

  logic        q_valid;
  logic        q_ready;
  stage_item_t q_item;

  vhd_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  vhd_back #(.N_STATES(N_STATES), .MAX_STAGES(MAX_STAGES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item), .out_ch(out_ch)
  );
endmodule
